// ===== hdl/iert_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// iert_pkg: types and constants shared by the echo reply tracker modules.
// No dependencies.

package iert_pkg;

    // item kinds on the input tuser
    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_REPLY  = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_FLUSH  = 2'd3
    } action_t;

    // result codes on the output tuser
    typedef enum logic [3:0] {
        STS_REGISTERED     = 4'd0,
        STS_TABLE_FULL     = 4'd1,
        STS_MATCHED        = 4'd2,
        STS_MALFORMED      = 4'd3,
        STS_UNMATCHED      = 4'd4,
        STS_CANCELLED      = 4'd5,
        STS_CANCEL_MISSING = 4'd6,
        STS_FLUSHED        = 4'd7,
        STS_DISABLED       = 4'd8
    } status_t;

    // configuration register indexes
    localparam logic CFG_ENGINE_ENABLE    = 1'b0;
    localparam logic CFG_PROBE_IDENTIFIER = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_LOOKUP = 4'b1000
    } state_t;

    // one table slot: valid flag and the probe key
    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [15:0] seq;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic [16:0] ETH_HDR_LEN  = 17'd14;
    localparam logic [16:0] IP_MIN_LEN   = 17'd20;
    localparam logic [16:0] ICMP_HDR_LEN = 17'd8;
    localparam logic [3:0]  IP_VERSION4  = 4'd4;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
    localparam logic [15:0] SEQ_LAST     = 16'hFFFF;

endpackage

`default_nettype wire

// ===== hdl/iert_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// iert_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.

module iert_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire                       re,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/icmp_echo_reply_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// icmp_echo_reply_tracker_top: outstanding echo probe table with reply matching.
// Depends on iert_pkg and iert_ram.
//
// Usage:
//   s_ channel carries one item per transfer: tuser selects send, reply, cancel
//   or flush, tdata carries the captured header fields. Every item gives exactly
//   one result transfer on the m_ channel, status on tuser, key and ttl on tdata.
//   cfg_ channel writes engine_enable (index 0) and probe_identifier (index 1);
//   it is always ready. Write it only while the block is idle; this is not enforced.
// Operation:
//   send, reply and cancel each pass through accept, table read, then
//   check and write-back into the output register. The table is a single RAM
//   with a registered read port; the slot is the sequence modulo
//   TABLE_DEPTH, its quotient worked out by a reciprocal multiply in the accept cycle.
//   A flush sweeps the table one slot a cycle.
// Reset:
//   after aresetn the table is swept clear one slot a cycle, s_tready low.
//   Control and configuration registers clear, next sequence is 1.
// Stall:
//   the result sits in the output register; the next item is accepted and read
//   while it waits, and the check stage holds until the output register frees.

module icmp_echo_reply_tracker_top
    import iert_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    // cap_len[15:0], version_ihl[23:16], ip_protocol[31:24], ip_ttl[39:32],
    // icmp_type[47:40], echo_id[63:48], echo_seq[79:64]
    input  wire  [79:0] s_tdata,
    // action[1:0]
    input  wire  [1:0]  s_tuser,

    output logic        m_tvalid,
    input  wire         m_tready,
    // result_seq[15:0], result_id[31:16], reply_ttl[39:32]
    output logic [39:0] m_tdata,
    // status[3:0]
    output logic [3:0]  m_tuser,

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_addr,
    input  wire  [15:0] cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
    // floor(seq / TABLE_DEPTH) == (seq * RECIP) >> 32 for every 16-bit seq
    localparam logic [31:0] RECIP = 32'((64'd4294967296 / TABLE_DEPTH) + 64'd1);

    // configuration
    logic        enable_reg;
    logic [15:0] ident_reg;

    // control
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             flush_pend_reg;
    logic [15:0]      next_seq_reg;
    logic [IDX_W-1:0] next_slot_reg;

    // captured item
    action_t     act_reg;
    logic [15:0] len_reg;
    logic [7:0]  vi_reg;
    logic [7:0]  proto_reg;
    logic [7:0]  ttl_reg;
    logic [7:0]  type_reg;
    logic [15:0] id_reg;
    logic [15:0] seq_reg;
    logic [15:0] quot_reg;
    logic [IDX_W-1:0] slot_reg;

    // output register
    logic        m_tvalid_reg;
    status_t     m_status_reg;
    logic [15:0] m_seq_reg;
    logic [15:0] m_id_reg;
    logic [7:0]  m_ttl_reg;

    // RAM ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    logic        s_accept;
    logic        out_free;
    logic        load;
    logic [47:0] quot_prod;
    logic [27:0] quot_times_depth;
    logic [15:0] rem_seq;

    status_t     res_status;
    logic [15:0] res_seq;
    logic [15:0] res_id;
    logic [7:0]  res_ttl;
    logic        wb_en;
    entry_t      wb_entry;
    logic        seq_adv;
    logic        key_hit;
    logic        well_formed;
    logic [16:0] hdr_min_len;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load      = (state_reg == ST_LOOKUP) && out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_ttl_reg, m_id_reg, m_seq_reg};

    // slot of a received sequence: seq - floor(seq / depth) * depth
    assign quot_prod        = 48'(s_tdata[79:64]) * 48'(RECIP);
    assign quot_times_depth = 28'(quot_reg) * 28'(TABLE_DEPTH);
    assign rem_seq          = seq_reg - quot_times_depth[15:0];

    iert_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_re    = (state_reg == ST_READ);
    assign ram_raddr = (act_reg == ACT_SEND) ? next_slot_reg : rem_seq[IDX_W-1:0];

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = load && wb_en;
            ram_waddr = slot_reg;
            ram_wdata = wb_entry;
        end
    end

    // reply header checks
    assign hdr_min_len = ETH_HDR_LEN + 17'({vi_reg[3:0], 2'b00}) + ICMP_HDR_LEN;
    assign well_formed = (17'(len_reg) >= ETH_HDR_LEN + IP_MIN_LEN)
                      && (vi_reg[7:4] == IP_VERSION4)
                      && (proto_reg == PROTO_ICMP)
                      && (17'(len_reg) >= hdr_min_len)
                      && (type_reg == ICMP_ECHO_REPLY);

    assign key_hit = ram_rdata.valid && (ram_rdata.id == id_reg)
                  && (ram_rdata.seq == seq_reg);

    always_comb begin
        res_status = STS_FLUSHED;
        res_seq    = '0;
        res_id     = '0;
        res_ttl    = '0;
        wb_en      = 1'b0;
        wb_entry   = '0;
        seq_adv    = 1'b0;
        case (act_reg)
            ACT_SEND: begin
                if (!enable_reg) begin
                    res_status = STS_DISABLED;
                end else begin
                    seq_adv = 1'b1;
                    res_seq = next_seq_reg;
                    res_id  = ident_reg;
                    if (ram_rdata.valid) begin
                        res_status = STS_TABLE_FULL;
                    end else begin
                        res_status = STS_REGISTERED;
                        wb_en      = 1'b1;
                        wb_entry   = '{valid: 1'b1, id: ident_reg, seq: next_seq_reg};
                    end
                end
            end
            ACT_REPLY: begin
                if (!enable_reg) begin
                    res_status = STS_DISABLED;
                end else if (!well_formed) begin
                    res_status = STS_MALFORMED;
                end else if (key_hit) begin
                    res_status = STS_MATCHED;
                    res_seq    = seq_reg;
                    res_id     = id_reg;
                    res_ttl    = ttl_reg;
                    wb_en      = 1'b1;
                end else begin
                    res_status = STS_UNMATCHED;
                end
            end
            ACT_CANCEL: begin
                if (key_hit) begin
                    res_status = STS_CANCELLED;
                    res_seq    = seq_reg;
                    res_id     = id_reg;
                    wb_en      = 1'b1;
                end else begin
                    res_status = STS_CANCEL_MISSING;
                end
            end
            default: begin
                res_status = STS_FLUSHED;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = flush_pend_reg ? ST_LOOKUP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (action_t'(s_tuser) == ACT_FLUSH) ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            flush_pend_reg <= 1'b0;
            next_seq_reg   <= 16'd1;
            next_slot_reg  <= IDX_W'(1);
            enable_reg     <= 1'b0;
            ident_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    CFG_ENGINE_ENABLE:    enable_reg <= cfg_data[0];
                    CFG_PROBE_IDENTIFIER: ident_reg  <= cfg_data;
                    default:              ident_reg  <= ident_reg;
                endcase
            end

            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= (clr_cnt_reg == LAST_SLOT) ? '0 : clr_cnt_reg + 1'b1;
            end

            if (s_accept && action_t'(s_tuser) == ACT_FLUSH) begin
                flush_pend_reg <= 1'b1;
            end else if (load) begin
                flush_pend_reg <= 1'b0;
            end

            // slot tracks next_seq mod depth; sequence zero maps to slot zero
            if (load && seq_adv) begin
                next_seq_reg <= next_seq_reg + 16'd1;
                if (next_seq_reg == SEQ_LAST || next_slot_reg == LAST_SLOT) begin
                    next_slot_reg <= '0;
                end else begin
                    next_slot_reg <= next_slot_reg + 1'b1;
                end
            end

            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg   <= action_t'(s_tuser);
            len_reg   <= s_tdata[15:0];
            vi_reg    <= s_tdata[23:16];
            proto_reg <= s_tdata[31:24];
            ttl_reg   <= s_tdata[39:32];
            type_reg  <= s_tdata[47:40];
            id_reg    <= s_tdata[63:48];
            seq_reg   <= s_tdata[79:64];
            quot_reg  <= quot_prod[47:32];
        end
        if (state_reg == ST_READ) begin
            slot_reg <= ram_raddr;
        end
        if (load) begin
            m_status_reg <= res_status;
            m_seq_reg    <= res_seq;
            m_id_reg     <= res_id;
            m_ttl_reg    <= res_ttl;
        end
    end

    // table is never read and written in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn) !(ram_re && ram_we))
        else $error("table read and write overlap");

    // a registered probe always leaves a valid entry behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res_status == STS_REGISTERED) |-> (ram_we && ram_wdata.valid))
        else $error("registered probe without table write");

    // an enabled send consumes exactly one sequence number
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && act_reg == ACT_SEND && enable_reg)
        |=> (next_seq_reg == $past(next_seq_reg) + 16'd1))
        else $error("sequence did not advance by one");

    // a result only appears from the check stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result raised outside check stage");

endmodule

`default_nettype wire
